FILE: src/rrs_pkg.sv
// Package: types, sizes and helpers for the radix rank sort unit.
`default_nettype none
package rrs_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int BUCKETS   = 256;
  localparam int DIGITS    = 4;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DIG_W     = $clog2(DIGITS);
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int HIST_W    = DIG_W + BKT_W;
  localparam int HIST_D    = DIGITS * BUCKETS;
  localparam int KEY_W     = 32;
  localparam int RANK_W    = 10;
  localparam int POS_W     = 10;
  localparam int BUF_W     = IDX_W + KEY_W;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  value;
    logic              last;
    logic [POS_W-1:0]  position;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              valid_res;
    logic              overflow;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PUSH, S_SORT, S_SKK, S_SKL, S_SKH, S_SKC,
    S_PFX, S_SC0, S_SC1, S_SC2, S_NEXT, S_FETCH
  } state_t;

  function automatic logic [BKT_W-1:0] key_byte(input logic [KEY_W-1:0] k,
                                                 input logic [DIG_W-1:0] d);
    return BKT_W'(k >> {d, 3'b000});
  endfunction

endpackage
`default_nettype wire

FILE: src/rrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module rrs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/lsd_radix_rank_sort_unit.sv
// Top level: LSD radix rank sort of 32-bit keys with push and fetch transactions.
//
//  channel | ports                        | transfer
//  --------+------------------------------+-------------------------------
//  input   | start, busy, in_item         | start high while busy low
//  result  | out_strobe, out_item         | one cycle, strobe high
//
// A push is the accepting cycle plus four read-modify-writes on the histogram
// RAM, each digit's read overlapping the previous digit's write. The push
// marked last then sorts: the first key is fetched, each digit gets a skip
// check and advance, and each pass not skipped runs a prefix sum over the
// buckets plus, per key, a source read, a bucket pointer read and a write;
// then a sweep clears the histograms. A fetch moves from its accepting cycle
// to S_FETCH, which strobes the result. Reset runs the same clearing sweep
// with busy high. The receiver cannot stall: results appear once, on out_strobe.
`default_nettype none
module lsd_radix_rank_sort_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire rrs_pkg::in_t in_item,
  output logic              out_strobe,
  output rrs_pkg::out_t     out_item
);
  import rrs_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              sorted_r, sorted_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ident_r, ident_nxt;   // no pass ran: ranks are identity
  logic              first_r, first_nxt;   // next pass reads the key store
  logic              cur_r, cur_nxt;       // buffer holding latest pass: 0=a 1=b
  logic              last_r, last_nxt;
  logic [KEY_W-1:0]  val_r, val_nxt;
  logic [KEY_W-1:0]  key0_r, key0_nxt;
  logic [KEY_W-1:0]  skey_r, skey_nxt;
  logic [IDX_W-1:0]  srank_r, srank_nxt;
  logic [2:0]        ph_r, ph_nxt;
  logic [DIG_W-1:0]  d_r, d_nxt;
  logic [BKT_W:0]    pb_r, pb_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic [HIST_W-1:0] clr_r, clr_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              fval_r, fval_nxt;

  // memory ports
  logic              ks_we;
  logic [IDX_W-1:0]  ks_wa, ks_ra;
  logic [KEY_W-1:0]  ks_wd, ks_rd;
  logic              h_we;
  logic [HIST_W-1:0] h_wa, h_ra;
  logic [CNT_W-1:0]  h_wd, h_rd;
  logic              bp_we;
  logic [BKT_W-1:0]  bp_wa, bp_ra;
  logic [CNT_W-1:0]  bp_wd, bp_rd;
  logic              ba_we, bb_we;
  logic [IDX_W-1:0]  buf_wa, buf_ra;
  logic [BUF_W-1:0]  buf_wd, ba_rd, bb_rd, src_rd;

  logic              accept;
  logic [CNT_W-1:0]  base_cnt;
  logic [2:0]        ph_m1;
  logic [KEY_W-1:0]  src_key;
  logic [IDX_W-1:0]  src_rank;

  rrs_ram #(.DEPTH(MAX_ITEMS), .WIDTH(KEY_W)) u_keys (
    .clk, .we(ks_we), .waddr(ks_wa), .wdata(ks_wd), .raddr(ks_ra), .rdata(ks_rd));
  rrs_ram #(.DEPTH(HIST_D), .WIDTH(CNT_W)) u_hist (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  rrs_ram #(.DEPTH(BUCKETS), .WIDTH(CNT_W)) u_bptr (
    .clk, .we(bp_we), .waddr(bp_wa), .wdata(bp_wd), .raddr(bp_ra), .rdata(bp_rd));
  rrs_ram #(.DEPTH(MAX_ITEMS), .WIDTH(BUF_W)) u_buf_a (
    .clk, .we(ba_we), .waddr(buf_wa), .wdata(buf_wd), .raddr(buf_ra), .rdata(ba_rd));
  rrs_ram #(.DEPTH(MAX_ITEMS), .WIDTH(BUF_W)) u_buf_b (
    .clk, .we(bb_we), .waddr(buf_wa), .wdata(buf_wd), .raddr(buf_ra), .rdata(bb_rd));

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign base_cnt = sorted_r ? '0 : count_r;
  assign ph_m1  = ph_r - 3'd1;
  assign src_rd = cur_r ? bb_rd : ba_rd;
  // first pass takes keys straight from the key store with identity ranks
  assign src_key  = first_r ? ks_rd : src_rd[KEY_W-1:0];
  assign src_rank = first_r ? i_r[IDX_W-1:0] : src_rd[BUF_W-1:KEY_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      count_r  <= '0;
      sorted_r <= 1'b0;
      ovf_r    <= 1'b0;
      ident_r  <= 1'b1;
      first_r  <= 1'b1;
      cur_r    <= 1'b0;
      clr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sorted_r <= sorted_nxt;
      ovf_r    <= ovf_nxt;
      ident_r  <= ident_nxt;
      first_r  <= first_nxt;
      cur_r    <= cur_nxt;
      clr_r    <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    val_r   <= val_nxt;
    key0_r  <= key0_nxt;
    skey_r  <= skey_nxt;
    srank_r <= srank_nxt;
    ph_r    <= ph_nxt;
    d_r     <= d_nxt;
    pb_r    <= pb_nxt;
    i_r     <= i_nxt;
    sum_r   <= sum_nxt;
    pos_r   <= pos_nxt;
    fval_r  <= fval_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    sorted_nxt = sorted_r;
    ovf_nxt   = ovf_r;
    ident_nxt = ident_r;
    first_nxt = first_r;
    cur_nxt   = cur_r;
    clr_nxt   = clr_r;
    last_nxt  = last_r;
    val_nxt   = val_r;
    key0_nxt  = key0_r;
    skey_nxt  = skey_r;
    srank_nxt = srank_r;
    ph_nxt    = ph_r;
    d_nxt     = d_r;
    pb_nxt    = pb_r;
    i_nxt     = i_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    fval_nxt  = fval_r;

    ks_we = 1'b0; ks_wa = count_r[IDX_W-1:0]; ks_wd = in_item.value;
    ks_ra = i_r[IDX_W-1:0];
    h_we = 1'b0; h_wa = clr_r; h_wd = '0; h_ra = {d_r, key_byte(key0_r, d_r)};
    bp_we = 1'b0; bp_wa = pb_r[BKT_W-1:0]; bp_wd = sum_r;
    bp_ra = key_byte(src_key, d_r);
    ba_we = 1'b0; bb_we = 1'b0;
    buf_wa = bp_rd[IDX_W-1:0]; buf_wd = {srank_r, skey_r};
    buf_ra = i_r[IDX_W-1:0];

    out_strobe = 1'b0;
    out_item   = '0;

    case (state_r)
      S_CLEAR: begin
        // sweep the histograms back to zero
        h_we = 1'b1;
        h_wa = clr_r;
        h_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == HIST_W'(HIST_D - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_item.command == CMD_PUSH) begin
            if (sorted_r) begin
              count_nxt  = '0;
              sorted_nxt = 1'b0;
              ovf_nxt    = 1'b0;
            end
            last_nxt = in_item.last;
            val_nxt  = in_item.value;
            if (base_cnt < CNT_W'(MAX_ITEMS)) begin
              ks_we  = 1'b1;
              ks_wa  = base_cnt[IDX_W-1:0];
              ph_nxt = '0;
              state_nxt = S_PUSH;
            end else begin
              ovf_nxt = 1'b1;
              if (in_item.last) begin
                state_nxt = S_SORT;
              end
            end
          end else begin
            pos_nxt  = in_item.position;
            fval_nxt = sorted_r && (32'(in_item.position) < 32'(count_r));
            buf_ra   = IDX_W'(in_item.position);
            state_nxt = S_FETCH;
          end
        end
      end
      S_PUSH: begin
        // read bin of digit ph, write back bin of digit ph-1 plus one
        h_ra = {ph_r[DIG_W-1:0], key_byte(val_r, ph_r[DIG_W-1:0])};
        if (ph_r != 3'd0) begin
          h_we = 1'b1;
          h_wa = {ph_m1[DIG_W-1:0], key_byte(val_r, ph_m1[DIG_W-1:0])};
          h_wd = h_rd + 1'b1;
        end
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'(DIGITS)) begin
          count_nxt = count_r + 1'b1;
          state_nxt = last_r ? S_SORT : S_IDLE;
        end
      end
      S_SORT: begin
        ident_nxt = 1'b1;
        first_nxt = 1'b1;
        cur_nxt   = 1'b0;
        d_nxt     = '0;
        if (count_r == '0) begin
          sorted_nxt = 1'b1;
          clr_nxt    = '0;
          state_nxt  = S_CLEAR;
        end else begin
          state_nxt = S_SKK;
        end
      end
      S_SKK: begin
        ks_ra = '0;
        state_nxt = S_SKL;
      end
      S_SKL: begin
        key0_nxt = ks_rd;
        state_nxt = S_SKH;
      end
      S_SKH: begin
        h_ra = {d_r, key_byte(key0_r, d_r)};
        state_nxt = S_SKC;
      end
      S_SKC: begin
        // skip the digit when one bucket holds every key
        if (h_rd == count_r) begin
          state_nxt = S_NEXT;
        end else begin
          pb_nxt  = '0;
          sum_nxt = '0;
          state_nxt = S_PFX;
        end
      end
      S_PFX: begin
        h_ra = {d_r, pb_r[BKT_W-1:0]};
        if (pb_r != '0) begin
          bp_we = 1'b1;
          bp_wa = BKT_W'(pb_r - 1'b1);
          bp_wd = sum_r;
          sum_nxt = sum_r + h_rd;
        end
        pb_nxt = pb_r + 1'b1;
        if (pb_r == (BKT_W+1)'(BUCKETS)) begin
          i_nxt = '0;
          state_nxt = S_SC0;
        end
      end
      S_SC0: begin
        ks_ra  = i_r[IDX_W-1:0];
        buf_ra = i_r[IDX_W-1:0];
        state_nxt = S_SC1;
      end
      S_SC1: begin
        skey_nxt  = src_key;
        srank_nxt = src_rank;
        bp_ra = key_byte(src_key, d_r);
        state_nxt = S_SC2;
      end
      S_SC2: begin
        // scatter into the other buffer and advance the bucket pointer
        buf_wa = bp_rd[IDX_W-1:0];
        buf_wd = {srank_r, skey_r};
        if (bp_rd < CNT_W'(MAX_ITEMS)) begin
          ba_we = cur_r;
          bb_we = !cur_r;
        end
        bp_we = 1'b1;
        bp_wa = key_byte(skey_r, d_r);
        bp_wd = bp_rd + 1'b1;
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == count_r) begin
          first_nxt = 1'b0;
          ident_nxt = 1'b0;
          cur_nxt   = !cur_r;
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_SC0;
        end
      end
      S_NEXT: begin
        if (d_r == DIG_W'(DIGITS - 1)) begin
          sorted_nxt = 1'b1;
          clr_nxt    = '0;
          state_nxt  = S_CLEAR;
        end else begin
          d_nxt = d_r + 1'b1;
          state_nxt = S_SKH;
        end
      end
      S_FETCH: begin
        out_strobe = 1'b1;
        out_item.overflow  = ovf_r;
        out_item.valid_res = fval_r;
        if (fval_r) begin
          out_item.rank = ident_r ? RANK_W'(pos_r) : RANK_W'(src_rd[BUF_W-1:KEY_W]);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire
